>>> sv/kbfc_pkg.sv
`default_nettype none

package kbfc_pkg;

	localparam int unsigned KeyBytes   = 32;
	localparam int unsigned KeyWords   = 4;
	localparam int unsigned WordBytes  = KeyBytes / KeyWords;
	localparam int unsigned WordWidth  = WordBytes * 8;
	localparam int unsigned KeyPosW    = $clog2(KeyBytes);
	localparam int unsigned CfgIdxW    = 3;
	localparam int unsigned CfgDataW   = WordWidth;

	typedef logic [7:0]              byte_t;
	typedef logic [KeyPosW-1:0]      key_pos_t;
	typedef logic [CfgIdxW-1:0]      cfg_idx_t;
	typedef logic [CfgDataW-1:0]     cfg_data_t;
	typedef logic [WordWidth-1:0]    key_word_t;

	// register map
	localparam cfg_idx_t RegStageKind = 3'd0;
	localparam cfg_idx_t RegDirection = 3'd1;
	localparam cfg_idx_t RegSeed      = 3'd2;
	localparam cfg_idx_t RegKey0      = 3'd3;
	localparam cfg_idx_t RegKey1      = 3'd4;
	localparam cfg_idx_t RegKey2      = 3'd5;
	localparam cfg_idx_t RegKey3      = 3'd6;

	localparam logic KindRotated = 1'b0;
	localparam logic KindChain   = 1'b1;
	localparam logic DirEncode   = 1'b0;
	localparam logic DirDecode   = 1'b1;

	function automatic byte_t rotl1(input byte_t v);
		return {v[6:0], v[7]};
	endfunction

endpackage

`default_nettype wire

>>> sv/kbfc_if.sv
`default_nettype none

interface kbfc_in_if import kbfc_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t in_byte;
	logic  last;

	modport source (output valid, output in_byte, output last, input ready);
	modport sink   (input valid, input in_byte, input last, output ready);
endinterface

interface kbfc_out_if import kbfc_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t out_byte;
	logic  out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

>>> sv/keyed_byte_feedback_cipher_unit.sv
// The result is registered: it shows at out_ch in the cycle after acceptance.
// One byte per cycle while out_ch is ready. The feedback byte loops through the
// XORs and rotate, the key position through an increment.
// The result register frees itself in the cycle it is taken, so input and output
// stream together. Reset (arst_n low, asynchronous) arms the message-start flag,
// empties the result register and clears all other registers to zero.
`default_nettype none

module keyed_byte_feedback_cipher_unit import kbfc_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      wr_en,
	input  wire cfg_idx_t  wr_index,
	input  wire cfg_data_t wr_data,
	kbfc_in_if.sink        in_ch,
	kbfc_out_if.source     out_ch
);

	// configuration
	logic      stage_kind_q;
	logic      direction_q;
	byte_t     seed_q;
	key_word_t key_q [KeyWords];

	// per-stream state
	byte_t    fb_q;
	key_pos_t pos_q;
	logic     start_q;

	// result register
	logic  out_valid_s1;
	byte_t out_byte_s1;
	logic  out_last_s1;

	logic     in_acc;
	byte_t    fb_cur;
	key_pos_t pos_cur;
	byte_t    fb_mix;
	byte_t    key_cur;
	byte_t    result;
	logic [$clog2(KeyWords)-1:0]  word_sel;
	logic [$clog2(WordBytes)-1:0] byte_sel;

	// output register is free when empty or being drained this cycle
	assign in_ch.ready = !out_valid_s1 || out_ch.ready;
	assign in_acc      = in_ch.valid && in_ch.ready;

	// a message start reloads seed and restarts the key stream
	assign fb_cur  = start_q ? seed_q : fb_q;
	assign pos_cur = start_q ? '0 : pos_q;

	assign word_sel = pos_cur[KeyPosW-1 -: $clog2(KeyWords)];
	assign byte_sel = pos_cur[$clog2(WordBytes)-1:0];

	always_comb begin
		key_cur = key_q[word_sel][byte_sel*8 +: 8];
		fb_mix  = (stage_kind_q == KindChain) ? fb_cur : rotl1(fb_cur);
		result  = in_ch.in_byte ^ fb_mix ^ key_cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_kind_q <= KindRotated;
			direction_q  <= DirEncode;
			seed_q       <= '0;
			for (int i = 0; i < KeyWords; i++) key_q[i] <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				RegStageKind: stage_kind_q <= wr_data[0];
				RegDirection: direction_q  <= wr_data[0];
				RegSeed:      seed_q       <= wr_data[7:0];
				RegKey0:      key_q[0]     <= wr_data;
				RegKey1:      key_q[1]     <= wr_data;
				RegKey2:      key_q[2]     <= wr_data;
				RegKey3:      key_q[3]     <= wr_data;
				default:      ; // unmapped index, write dropped
			endcase
		end
	end

	// ciphertext feedback: the result when encoding, the input when decoding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_q    <= '0;
			pos_q   <= '0;
			start_q <= 1'b1;
		end else if (in_acc) begin
			fb_q    <= (direction_q == DirDecode) ? in_ch.in_byte : result;
			pos_q   <= pos_cur + key_pos_t'(1);
			start_q <= in_ch.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s1 <= 1'b0;
			out_byte_s1  <= '0;
			out_last_s1  <= 1'b0;
		end else if (in_ch.ready) begin
			out_valid_s1 <= in_ch.valid;
			if (in_ch.valid) begin
				out_byte_s1 <= result;
				out_last_s1 <= in_ch.last;
			end
		end
	end

	assign out_ch.valid    = out_valid_s1;
	assign out_ch.out_byte = out_byte_s1;
	assign out_ch.out_last = out_last_s1;

`ifndef SYNTHESIS
	a_last_arms_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (start_q == $past(in_ch.last)))
		else $error("message start flag does not follow last");

	a_pos_advances: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !start_q |=> (pos_q == $past(pos_q) + key_pos_t'(1)))
		else $error("key position did not advance");

	a_decode_feedback: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && direction_q == DirDecode |=> (fb_q == $past(in_ch.in_byte)))
		else $error("decode feedback is not the input byte");

	a_encode_feedback: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && direction_q == DirEncode |=> (fb_q == out_byte_s1))
		else $error("encode feedback differs from the result");

	a_valid_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_s1) |-> $past(in_acc))
		else $error("result appeared without an accepted request");
`endif

endmodule

`default_nettype wire

>>> tb/keyed_byte_feedback_cipher_unit_tb.sv
`timescale 1ns / 100ps

module keyed_byte_feedback_cipher_unit_tb;
	import kbfc_pkg::*;

	localparam int unsigned ByteCount  = 1750;   // random bytes to push through
	localparam int unsigned CycleLimit = 200000; // far beyond the slowest legal run
	localparam int unsigned IdlePct    = 24;     // idle cycles per hundred, each side
	localparam cfg_idx_t    RegUnused  = 3'd7;   // decodes to no register
	localparam key_word_t   AllOnes    = '1;
	localparam key_word_t   AllZeros   = '0;

	typedef struct packed {
		byte_t data;
		logic  last;
	} cipher_out_t;

	// Mirrors the cipher stage: config copy, feedback chain and key position.
	// Each accepted request queues its expected result; each result takes one.
	class cipher_scoreboard;
		logic        kind;
		logic        dir;
		byte_t       seed_byte;
		key_word_t   key_word[KeyWords];
		byte_t       chain_byte;
		key_pos_t    key_pos;
		logic        msg_start;
		cipher_out_t due_q[$];
		int unsigned errors;

		function new();
			kind       = KindRotated;
			dir        = DirEncode;
			seed_byte  = '0;
			foreach (key_word[i])
				key_word[i] = '0;
			chain_byte = '0;
			key_pos    = '0;
			msg_start  = 1'b1;
			errors     = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, cfg_data_t data);
			case (idx)
				RegStageKind: kind         = data[0];
				RegDirection: dir          = data[0];
				RegSeed:      seed_byte    = data[7:0];
				RegKey0:      key_word[0]  = data;
				RegKey1:      key_word[1]  = data;
				RegKey2:      key_word[2]  = data;
				RegKey3:      key_word[3]  = data;
				default:      ;
			endcase
		endfunction

		function void predict_cipher(byte_t data, logic last);
			byte_t       mix;
			byte_t       key;
			cipher_out_t res;
			if (msg_start) begin
				chain_byte = seed_byte;
				key_pos    = '0;
			end
			mix = (kind == KindChain) ? chain_byte : {chain_byte[6:0], chain_byte[7]};
			key = key_word[key_pos[4:3]][{key_pos[2:0], 3'b000} +: 8];
			res.data = data ^ mix ^ key;
			res.last = last;
			// both directions chain on ciphertext
			chain_byte = (dir == DirDecode) ? data : res.data;
			key_pos    = key_pos + 1'b1;
			msg_start  = last;
			due_q.insert(due_q.size(), res);
		endfunction

		function void check_result(byte_t got_data, logic got_last);
			cipher_out_t want;
			if (due_q.size() == 0) begin
				$display("%0t: unexpected result out_byte %02h out_last %b",
					$time, got_data, got_last);
				errors++;
				return;
			end
			want = due_q.pop_front();
			if (got_data !== want.data) begin
				$display("%0t: out_byte expected %02h actual %02h",
					$time, want.data, got_data);
				errors++;
			end
			if (got_last !== want.last) begin
				$display("%0t: out_last expected %b actual %b",
					$time, want.last, got_last);
				errors++;
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      wr_en;
	cfg_idx_t  wr_index;
	cfg_data_t wr_data;
	logic      steady;        // both sides run without idling while set
	int unsigned sent;        // requests accepted so far
	int unsigned cycles;

	cipher_scoreboard sb;

	kbfc_in_if  in_ch();
	kbfc_out_if out_ch();

	keyed_byte_feedback_cipher_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	// 8 ns clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Hard stop in case the handshake hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	// Sample at the rising edge. The result checked here can only belong to an
	// earlier request, so check before noting this edge's request. Config
	// writes never share an edge with a request.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready)
				sb.check_result(out_ch.out_byte, out_ch.out_last);
			if (in_ch.valid && in_ch.ready)
				sb.predict_cipher(in_ch.in_byte, in_ch.last);
			if (wr_en)
				sb.write_reg(wr_index, wr_data);
		end
	end

	// Downstream backpressure, changed on the falling edge.
	always @(negedge clk) begin
		out_ch.ready <= steady || ($urandom_range(99) >= IdlePct);
	end

	function automatic byte_t pick_byte();
		case ($urandom_range(9))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return byte_t'($urandom_range(255));
		endcase
	endfunction

	function automatic key_word_t pick_word();
		case ($urandom_range(5))
			0:       return AllZeros;
			1:       return AllOnes;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// One register write; the enable is up for exactly one edge.
	task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(negedge clk);
		wr_en    <= 1'b0;
	endtask

	// Present one request, with random idle cycles ahead of it, and hold it
	// until the block takes it.
	task automatic send_byte(byte_t data, logic last);
		while (!steady && $urandom_range(99) < IdlePct) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
		end
		@(negedge clk);
		in_ch.valid   <= 1'b1;
		in_ch.in_byte <= data;
		in_ch.last    <= last;
		do
			@(posedge clk);
		while (in_ch.ready !== 1'b1);
		sent++;
	endtask

	// close = 0 leaves the message open, so the next phase's writes land
	// mid-message.
	task automatic send_message(int unsigned len, bit close);
		for (int unsigned i = 0; i < len; i++)
			send_byte(pick_byte(), close && (i == len - 1));
	endtask

	// Drop valid and wait for the block to drain, leaving it fully idle.
	task automatic settle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (sb.due_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Rewrite a random subset of the registers, now and then poking the
	// unmapped index too.
	task automatic shuffle_config();
		if ($urandom_range(1))
			write_reg(RegStageKind,
				cfg_data_t'($urandom_range(1) ? KindChain : KindRotated));
		if ($urandom_range(1))
			write_reg(RegDirection,
				cfg_data_t'($urandom_range(1) ? DirDecode : DirEncode));
		if ($urandom_range(1))
			write_reg(RegSeed, cfg_data_t'(pick_byte()));
		if ($urandom_range(2) == 0)
			write_reg(RegKey0, pick_word());
		if ($urandom_range(2) == 0)
			write_reg(RegKey1, pick_word());
		if ($urandom_range(2) == 0)
			write_reg(RegKey2, pick_word());
		if ($urandom_range(2) == 0)
			write_reg(RegKey3, pick_word());
		if ($urandom_range(7) == 0)
			write_reg(RegUnused, {$urandom, $urandom});
	endtask

	initial begin
		int unsigned phase;
		int unsigned msgs;
		int unsigned len;

		sb            = new();
		arst_n        = 1'b0;
		wr_en         = 1'b0;
		wr_index      = RegStageKind;
		wr_data       = '0;
		in_ch.valid   = 1'b0;
		in_ch.in_byte = '0;
		in_ch.last    = 1'b0;
		out_ch.ready  = 1'b0;
		steady        = 1'b0;
		sent          = 0;
		cycles        = 0;
		phase         = 0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset config: all-zero key and seed, rotated encode.
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		settle();

		// Every mode pairing once, seed and key words 0 and 1 at their extremes.
		// Pass 1 starts with a one-byte message; pass 2 leaves its message
		// open so pass 3 rewrites everything mid-message (seed unused there).
		for (int m = 0; m < 4; m++) begin
			write_reg(RegStageKind, cfg_data_t'(m[0] ? KindChain : KindRotated));
			write_reg(RegDirection, cfg_data_t'(m[1] ? DirDecode : DirEncode));
			write_reg(RegSeed, cfg_data_t'(m[0] ? 8'h00 : 8'hFF));
			write_reg(RegKey0, m[0] ? AllOnes : AllZeros);
			write_reg(RegKey1, m[0] ? AllZeros : AllOnes);
			write_reg(RegKey2, 64'h5555_5555_5555_5555);
			write_reg(RegKey3, 64'hAAAA_AAAA_AAAA_AAAA);
			if (m == 0)
				write_reg(RegUnused, AllOnes);
			send_byte(8'h00, m == 1);
			send_byte(8'hFF, 1'b0);
			send_byte(pick_byte(), 1'b0);
			send_byte(8'h80, m != 2);
			settle();
		end

		// Random phases: new config, then a batch of messages. Mostly short
		// ones, some long enough to wrap the key position. One early stretch
		// of phases runs with no idling on either side.
		while (sent < ByteCount) begin
			phase++;
			steady = (phase >= 6 && phase < 10);
			shuffle_config();
			msgs = $urandom_range(1, 8);
			repeat (msgs) begin
				case ($urandom_range(9))
					0:       len = 1;
					1, 2:    len = $urandom_range(33, 70);
					default: len = $urandom_range(2, 20);
				endcase
				send_message(len, 1'b1);
			end
			if ($urandom_range(3) == 0)
				send_message($urandom_range(1, 5), 1'b0);
			settle();
		end
		steady = 1'b0;

		if (sb.errors == 0 && sb.due_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> files.f
sv/kbfc_pkg.sv
sv/kbfc_if.sv
sv/keyed_byte_feedback_cipher_unit.sv
tb/keyed_byte_feedback_cipher_unit_tb.sv
